FILE: rtl/dmic_pkg.sv
// Shared types and constants for the direct-mapped instruction cache tag model.
// Holds the sequencer state type and the cacheable region codes.
// No dependencies.
package dmic_pkg;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_READY,
      S_LOOKUP
   } dmic_state_type;

   localparam int unsigned REGION_SHIFT = 28;
   localparam int unsigned REGION_W     = 4;

   localparam logic [REGION_W-1:0] REGION_FLASH    = 4'h3;
   localparam logic [REGION_W-1:0] REGION_SDRAM_LO = 4'hA;
   localparam logic [REGION_W-1:0] REGION_SDRAM_HI = 4'hB;

   localparam int unsigned ADDR_W    = 32;
   localparam int unsigned COUNT_W   = 64;
   localparam int unsigned RSP_W     = 264;

   function automatic logic region_cacheable(input logic [ADDR_W-1:0] addr);
      logic [REGION_W-1:0] region;
      region = addr[REGION_SHIFT +: REGION_W];
      return (region == REGION_FLASH) || (region == REGION_SDRAM_LO) ||
             (region == REGION_SDRAM_HI);
   endfunction

endpackage

FILE: rtl/dmic_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered: it is valid in the cycle after the read and held while no read is issued.
// No dependencies.
module dmic_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/direct_mapped_icache_tag_model_unit.sv
// Direct-mapped instruction cache tag model: top level.
// Depends on dmic_pkg and on dmic_ram for the combined valid and tag store.
//
// Usage:
//   req_* carries one 32-bit fetch address per request in req_tdata.
//   rsp_* returns one result per request: hit, cacheable and four 64-bit
//   wrapping counters (hits, misses, fetches, uncached fetches).
//   The address splits into byte offset, line index and tag from LINE_BYTES
//   and LINE_COUNT; only regions 0x3, 0xA and 0xB of bits 31:28 are cached.
// Timing:
//   A request is taken in S_READY and the tag store is read; in S_LOOKUP, once the
//   output register is free, the tag is compared, the line is filled on a cacheable
//   miss and the result is registered. A new request is taken only after the lookup
//   of the last one is done, set by the read-compare-write loop on the single tag
//   store.
// Reset:
//   Counters clear at once. The tag store is then swept clear, one line a cycle,
//   over all 2^floor(log2(LINE_COUNT)) lines; req_tready stays low meanwhile.
// Stall:
//   A result waiting on rsp_tready holds; the next request is still accepted
//   and read, and its lookup waits until the output register is free.
module direct_mapped_icache_tag_model_unit
   import dmic_pkg::*;
#(
   parameter int unsigned LINE_BYTES = 4,
   parameter int unsigned LINE_COUNT = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,  // [31:0] fetch_addr
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata   // [0] hit, [1] cacheable, [65:2] hits_so_far,
                                         // [129:66] misses_so_far, [193:130] fetches_so_far,
                                         // [257:194] uncached_so_far, [263:258] zero
);

   localparam int unsigned OB     = $clog2(LINE_BYTES + 1) - 1;
   localparam int unsigned IB     = $clog2(LINE_COUNT + 1) - 1;
   localparam int unsigned LINES  = 1 << IB;
   localparam int unsigned IDX_W  = (LINES > 1) ? $clog2(LINES) : 1;
   localparam int unsigned TAG_W  = ADDR_W - OB - IB;
   localparam int unsigned WORD_W = TAG_W + 1;
   localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(LINES - 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LINES - 1);
   localparam int unsigned PAD_W  = RSP_W - 2 - 4 * COUNT_W;

   dmic_state_type state_ff, state_in;

   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic [ADDR_W-1:0]  addr_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               hit_ff, cach_ff;
   logic [COUNT_W-1:0] hits_ff, misses_ff, fetches_ff, uncached_ff;
   logic [COUNT_W-1:0] hits_in, misses_in, fetches_in, uncached_in;

   logic               req_fire;
   logic               step;
   logic [IDX_W-1:0]   req_idx, lk_idx;
   logic [TAG_W-1:0]   lk_tag;
   logic               lk_cach, lk_hit;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [WORD_W-1:0]  wr_data, rd_data;

   assign req_fire = req_tvalid && req_tready;
   assign req_idx  = IDX_W'(req_tdata >> OB) & IDX_MASK;
   assign lk_idx   = IDX_W'(addr_ff >> OB) & IDX_MASK;
   assign lk_tag   = TAG_W'(addr_ff >> (OB + IB));
   assign lk_cach  = region_cacheable(addr_ff);
   assign lk_hit   = lk_cach && rd_data[TAG_W] && (rd_data[TAG_W-1:0] == lk_tag);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      req_tready   = 1'b0;
      step         = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = lk_idx;
      wr_data      = {1'b1, lk_tag};
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_LAST) begin
               state_in = S_READY;
            end
         end
         S_READY: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               step     = 1'b1;
               wr_en    = lk_cach && !lk_hit;
               state_in = S_READY;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      fetches_in   = fetches_ff;
      uncached_in  = uncached_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
         fetches_in   = fetches_ff + COUNT_W'(1);
         if (lk_hit) begin
            hits_in = hits_ff + COUNT_W'(1);
         end else begin
            misses_in = misses_ff + COUNT_W'(1);
         end
         if (!lk_cach) begin
            uncached_in = uncached_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         hits_ff      <= '0;
         misses_ff    <= '0;
         fetches_ff   <= '0;
         uncached_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         fetches_ff   <= fetches_in;
         uncached_ff  <= uncached_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         addr_ff <= req_tdata;
      end
      if (step) begin
         hit_ff  <= lk_hit;
         cach_ff <= lk_cach;
      end
   end

   dmic_ram #(
      .WIDTH (WORD_W),
      .DEPTH (LINES)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_idx),
      .rd_data (rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, uncached_ff, fetches_ff, misses_ff, hits_ff,
                        cach_ff, hit_ff};

   a_accept_to_lookup: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_LOOKUP)
      else $error("accepted request did not enter lookup");

   a_result_from_lookup: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == S_LOOKUP)
      else $error("result appeared without a lookup");

   a_hit_is_cacheable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(hit_ff && !cach_ff))
      else $error("hit reported on an uncacheable fetch");

   a_count_balance: assert property (@(posedge clock) disable iff (reset)
      fetches_ff == hits_ff + misses_ff)
      else $error("fetch count differs from hits plus misses");

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> !req_tready)
      else $error("request taken during tag store clear");

endmodule

FILE: verif/icache_tag_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the direct-mapped instruction cache tag model: watches both
// stream channels, predicts each result from its own tag store and counters.
// Depends on dmic_pkg for widths and region codes.
module icache_tag_checker
   import dmic_pkg::*;
#(
   parameter int unsigned LINE_BYTES = 4,
   parameter int unsigned LINE_COUNT = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [31:0]       req_tdata,  // [31:0] fetch_addr
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [RSP_W-1:0]  rsp_tdata,  // [0] hit, [1] cacheable, [65:2] hits_so_far,
                                         // [129:66] misses_so_far, [193:130] fetches_so_far,
                                         // [257:194] uncached_so_far, [263:258] zero
   output int                fail_count,
   output int                pending
);

   function automatic int unsigned floor_log2(input int unsigned x);
      int unsigned r;
      int unsigned v;
      r = 0;
      v = x;
      while (v > 1) begin
         v = v >> 1;
         r++;
      end
      return r;
   endfunction

   localparam int unsigned OFFSET_BITS = floor_log2(LINE_BYTES);
   localparam int unsigned SET_BITS    = floor_log2(LINE_COUNT);
   localparam logic [31:0] SET_MASK    = (SET_BITS >= 32) ? 32'hFFFF_FFFF
                                                          : ((32'd1 << SET_BITS) - 32'd1);
   localparam int unsigned USED_W      = 2 + 4 * COUNT_W;

   typedef struct packed {
      logic [COUNT_W-1:0] uncached;
      logic [COUNT_W-1:0] fetches;
      logic [COUNT_W-1:0] misses;
      logic [COUNT_W-1:0] hits;
      logic               cacheable;
      logic               hit;
   } fetch_outcome_type;

   logic [31:0]        line_tag_q   [LINE_COUNT];
   logic               line_valid_q [LINE_COUNT];
   logic [COUNT_W-1:0] hits_seen;
   logic [COUNT_W-1:0] misses_seen;
   logic [COUNT_W-1:0] fetches_seen;
   logic [COUNT_W-1:0] uncached_seen;
   fetch_outcome_type  outcome_q [$];
   int                 mismatches = 0;

   assign fail_count = mismatches;

   function automatic fetch_outcome_type lookup_fetch(input logic [ADDR_W-1:0] addr);
      logic [63:0]       wide;
      logic [31:0]       set_idx;
      logic [31:0]       tag;
      logic              cach;
      fetch_outcome_type o;
      wide    = 64'(addr);
      set_idx = 32'(wide >> OFFSET_BITS) & SET_MASK;
      tag     = 32'(wide >> (OFFSET_BITS + SET_BITS));
      case (addr[REGION_SHIFT +: REGION_W])
         REGION_FLASH, REGION_SDRAM_LO, REGION_SDRAM_HI: cach = 1'b1;
         default: cach = 1'b0;
      endcase
      fetches_seen = fetches_seen + 1'b1;
      o.hit = cach && line_valid_q[set_idx] && (line_tag_q[set_idx] == tag);
      if (o.hit) begin
         hits_seen = hits_seen + 1'b1;
      end else begin
         misses_seen = misses_seen + 1'b1;
         if (!cach) begin
            uncached_seen = uncached_seen + 1'b1;
         end else begin
            line_tag_q[set_idx]   = tag;
            line_valid_q[set_idx] = 1'b1;
         end
      end
      o.cacheable = cach;
      o.hits      = hits_seen;
      o.misses    = misses_seen;
      o.fetches   = fetches_seen;
      o.uncached  = uncached_seen;
      return o;
   endfunction

   task automatic compare_field(input string name, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      fetch_outcome_type want;
      if (reset) begin
         for (int i = 0; i < LINE_COUNT; i++) begin
            line_valid_q[i] = 1'b0;
            line_tag_q[i]   = '0;
         end
         hits_seen     = '0;
         misses_seen   = '0;
         fetches_seen  = '0;
         uncached_seen = '0;
         outcome_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            outcome_q.push_back(lookup_fetch(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               $error("rsp: result with no request outstanding");
               mismatches++;
            end else begin
               want = outcome_q.pop_front();
               compare_field("hit", 64'(want.hit), 64'(rsp_tdata[0]));
               compare_field("cacheable", 64'(want.cacheable), 64'(rsp_tdata[1]));
               compare_field("hits_so_far", want.hits, rsp_tdata[2 +: COUNT_W]);
               compare_field("misses_so_far", want.misses,
                             rsp_tdata[2 + COUNT_W +: COUNT_W]);
               compare_field("fetches_so_far", want.fetches,
                             rsp_tdata[2 + 2 * COUNT_W +: COUNT_W]);
               compare_field("uncached_so_far", want.uncached,
                             rsp_tdata[2 + 3 * COUNT_W +: COUNT_W]);
               compare_field("padding", 64'd0, 64'(rsp_tdata[RSP_W-1:USED_W]));
            end
         end
      end
      pending <= outcome_q.size();
   end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Top of the cache tag model testbench: clock, reset, fetch request stimulus
// and result back-pressure, a watchdog and the verdict.
// Depends on dmic_pkg, direct_mapped_icache_tag_model_unit and icache_tag_checker.
module testbench
   import dmic_pkg::*;
();

   localparam int unsigned LINE_BYTES   = 4;
   localparam int unsigned LINE_COUNT   = 16;
   localparam int unsigned OFFSET_BITS  = $clog2(LINE_BYTES);
   localparam int unsigned SET_BITS     = OFFSET_BITS + $clog2(LINE_COUNT);
   localparam int          RANDOM_ITEMS = 750;
   localparam int          QUIET_ITEMS  = 100;
   localparam int          DRAIN_CYCLES = 16;
   localparam int          STUCK_LIMIT  = 2000;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b1;
   logic [RSP_W-1:0]  rsp_tdata;
   int                fail_count;
   int                pending;
   int                stuck_cycles = 0;
   logic              quiet = 1'b0;
   logic [27:0]       tag_pool [4];
   logic [31:0]       last_fetch = 32'h3000_0000;

   direct_mapped_icache_tag_model_unit #(
      .LINE_BYTES (LINE_BYTES),
      .LINE_COUNT (LINE_COUNT)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   icache_tag_checker #(
      .LINE_BYTES (LINE_BYTES),
      .LINE_COUNT (LINE_COUNT)
   ) scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic send_fetch(input logic [31:0] addr);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= addr;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_fetch_addr();
      logic [31:0] a;
      logic [31:0] low_mask;
      logic [3:0]  region;
      int          sel;
      sel      = $urandom_range(0, 9);
      a        = $urandom;
      low_mask = (32'd1 << SET_BITS) - 32'd1;
      if (sel < 6) begin
         case ($urandom_range(0, 2))
            0: region = REGION_FLASH;
            1: region = REGION_SDRAM_LO;
            default: region = REGION_SDRAM_HI;
         endcase
         a = {region, 28'((32'(tag_pool[$urandom_range(0, 3)]) << SET_BITS) | (a & low_mask))};
      end else if (sel < 8) begin
         a = last_fetch ^ (a & ((32'd1 << OFFSET_BITS) - 32'd1));
      end else if (sel == 9) begin
         tag_pool[$urandom_range(0, 3)] = 28'($urandom);
      end
      last_fetch = a;
      return a;
   endfunction

   initial begin
      logic [31:0] directed [$];
      directed = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h3000_0000, 32'h3000_0003,
                   32'h3000_0004, 32'hA000_0000, 32'h3000_0000, 32'hA000_0040,
                   32'hBFFF_FFFC, 32'hBFFF_FFFF, 32'h2FFF_FFFF, 32'h4000_0000,
                   32'h9FFF_FFFC, 32'hC000_0000, 32'h7FFF_FFFC, 32'h3FFF_FFFC,
                   32'h3FFF_FFFC, 32'hAFFF_FFFC, 32'hB000_0000, 32'hB000_0000};
      for (int i = 0; i < 4; i++) tag_pool[i] = 28'($urandom);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_fetch(directed[i]);
      wait_drained();
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         if (n == RANDOM_ITEMS / 2) wait_drained();
         send_fetch(pick_fetch_addr());
      end
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (stuck_cycles >= STUCK_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

endmodule
